// ===== rtl/core/lsg_pkg.sv =====
// Shared types, constants and the color wheel function for the LED strip effect generator.
`timescale 1ns / 1ps
package lsg_pkg;

  localparam int MaxPixels = 64;

  // effect numbers
  localparam logic [4:0] ModeStatic      = 5'd0;
  localparam logic [4:0] ModeWipeRed     = 5'd1;
  localparam logic [4:0] ModeWipeGreen   = 5'd2;
  localparam logic [4:0] ModeWipeBlue    = 5'd3;
  localparam logic [4:0] ModeChaseWhite  = 5'd4;
  localparam logic [4:0] ModeChaseRed    = 5'd5;
  localparam logic [4:0] ModeChaseGreen  = 5'd6;
  localparam logic [4:0] ModeChaseBlue   = 5'd7;
  localparam logic [4:0] ModeRainbow     = 5'd8;
  localparam logic [4:0] ModeTvRainbow   = 5'd9;
  localparam logic [4:0] ModeRbChase     = 5'd10;
  localparam logic [4:0] ModeRunRed      = 5'd11;
  localparam logic [4:0] ModeRunGreen    = 5'd12;
  localparam logic [4:0] ModeRunBlue     = 5'd13;
  localparam logic [4:0] ModeRandom      = 5'd14;
  localparam logic [4:0] ModeSetPixel    = 5'd15;
  localparam logic [4:0] ModePurpleWipe  = 5'd16;
  localparam logic [4:0] ModePurpleRun   = 5'd17;
  localparam logic [4:0] ModeDemoLast    = 5'd14;

  // register indexes
  localparam logic [2:0] RegModeSelect  = 3'd0;
  localparam logic [2:0] RegDemoEnable  = 3'd1;
  localparam logic [2:0] RegStaticColor = 3'd2;
  localparam logic [2:0] RegFavColor    = 3'd3;
  localparam logic [2:0] RegStripLength = 3'd4;
  localparam logic [2:0] RegTvFirst     = 3'd5;
  localparam logic [2:0] RegPatternIvl  = 3'd6;

  // frame job kinds handed from front to back
  typedef enum logic [2:0] {
    JobFill,     // whole store = color
    JobPut,      // single pixel write (wipe)
    JobChase,    // clear, every third pixel from phase = color
    JobRunner,   // clear, one pixel = color
    JobRainbow,  // wheel((i+off) % 255)
    JobTv,       // wheel((i+off) & 255), black below tv_first
    JobRbChase   // every third pixel from phase = wheel, restored to black after emit
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] color;
    logic [5:0]  pos;
    logic [1:0]  phase;
    logic [7:0]  offset;
    logic [6:0]  tv_first;
    logic [6:0]  len;
  } job_t;

  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [9:0] p3;
    begin
      p = 8'd255 - pos;
      if (p < 8'd85) begin
        p3 = {2'b0, p} * 10'd3;
        wheel = {8'd255 - p3[7:0], 8'd0, p3[7:0]};
      end else if (p < 8'd170) begin
        p3 = {2'b0, p - 8'd85} * 10'd3;
        wheel = {8'd0, p3[7:0], 8'd255 - p3[7:0]};
      end else begin
        p3 = {2'b0, p - 8'd170} * 10'd3;
        wheel = {p3[7:0], 8'd255 - p3[7:0], 8'd0};
      end
    end
  endfunction

endpackage

// ===== rtl/core/lsg_front.sv =====
// Front end: timers, demo stepping, effect state and frame job issue.
`timescale 1ns / 1ps
module lsg_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick_valid,
  output logic             tick_ready,
  input  logic [3:0]       ms_elapsed,
  input  logic             wr_mode,
  input  logic [4:0]       wr_mode_val,
  input  logic             wr_static,
  input  logic             wr_demo,
  input  logic             demo_val,
  input  logic [23:0]      static_color,
  input  logic [23:0]      favorite_color,
  input  logic [6:0]       strip_len,
  input  logic [6:0]       tv_first_pixel,
  input  logic [15:0]      pattern_interval,
  output logic             demo_enable,
  output logic             job_valid,
  input  logic             job_ready,
  output lsg_pkg::job_t    job
);

  logic [15:0] frame_timer_r, demo_timer_r;
  logic [4:0]  mode_r;
  logic [8:0]  interval_r;
  logic [5:0]  wipe_pos_r, run_pos_r;
  logic        blank_r, drawn_r, demo_r;
  logic [1:0]  chase_r, rbc_r;
  logic [7:0]  off_r;
  logic        hold_r;
  lsg_pkg::job_t hold_job_r;

  assign tick_ready  = !hold_r;
  assign job_valid   = hold_r;
  assign job         = hold_job_r;
  assign demo_enable = demo_r;

  logic [16:0] ft_sum, dt_sum;
  logic [15:0] ft, dt;
  logic [4:0]  mode_step, mode_inc;
  logic        fire;
  logic [6:0]  wp_inc, rp_inc;
  logic [6:0]  len_eff;

  always_comb begin
    ft_sum = {1'b0, frame_timer_r} + {13'd0, ms_elapsed};
    dt_sum = {1'b0, demo_timer_r} + {13'd0, ms_elapsed};
    ft = ft_sum[16] ? 16'hFFFF : ft_sum[15:0];
    dt = dt_sum[16] ? 16'hFFFF : dt_sum[15:0];
    mode_inc = mode_r + 5'd1;
    mode_step = mode_r;
    if (demo_r && dt >= pattern_interval)
      mode_step = (mode_inc > lsg_pkg::ModeDemoLast || mode_inc == 5'd0) ? 5'd1 : mode_inc;
    fire = ft >= {7'd0, interval_r};
    // lengths beyond the store act as a full store
    len_eff = (strip_len > 7'(lsg_pkg::MaxPixels)) ? 7'(lsg_pkg::MaxPixels) : strip_len;
    wp_inc = {1'b0, wipe_pos_r} + 7'd1;
    rp_inc = {1'b0, run_pos_r} + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_timer_r <= '0; demo_timer_r <= '0; mode_r <= '0; interval_r <= 9'd50;
      wipe_pos_r <= '0; run_pos_r <= '0; blank_r <= 1'b0; drawn_r <= 1'b0;
      demo_r <= 1'b0; chase_r <= '0; rbc_r <= '0; off_r <= '0; hold_r <= 1'b0;
    end else begin
      if (hold_r && job_ready) hold_r <= 1'b0;
      if (wr_demo) demo_r <= demo_val;
      if (wr_mode) begin mode_r <= wr_mode_val; drawn_r <= 1'b0; end
      if (wr_static) drawn_r <= 1'b0;
      if (tick_valid && tick_ready) begin
        frame_timer_r <= ft;
        demo_timer_r  <= (demo_r && dt >= pattern_interval) ? 16'd0 : dt;
        mode_r        <= mode_step;
        hold_job_r.color    <= '0;
        hold_job_r.pos      <= '0;
        hold_job_r.phase    <= '0;
        hold_job_r.offset   <= off_r;
        hold_job_r.tv_first <= tv_first_pixel;
        hold_job_r.len      <= strip_len;
        if (fire) begin
          frame_timer_r <= '0;
          case (mode_step)
            lsg_pkg::ModeWipeRed, lsg_pkg::ModeWipeGreen, lsg_pkg::ModeWipeBlue,
            lsg_pkg::ModePurpleWipe: begin
              interval_r <= 9'd50;
              hold_r <= 1'b1;
              hold_job_r.kind <= lsg_pkg::JobPut;
              hold_job_r.pos  <= wipe_pos_r;
              hold_job_r.color <= blank_r ? 24'd0 :
                (mode_step == lsg_pkg::ModeWipeRed)   ? 24'hFF0000 :
                (mode_step == lsg_pkg::ModeWipeGreen) ? 24'h00FF00 :
                (mode_step == lsg_pkg::ModeWipeBlue)  ? 24'h0000FF : favorite_color;
              if (wp_inc >= len_eff) begin wipe_pos_r <= '0; blank_r <= !blank_r; end
              else wipe_pos_r <= wp_inc[5:0];
            end
            lsg_pkg::ModeChaseWhite, lsg_pkg::ModeChaseRed, lsg_pkg::ModeChaseGreen,
            lsg_pkg::ModeChaseBlue: begin
              interval_r <= 9'd50;
              hold_r <= 1'b1;
              hold_job_r.kind  <= lsg_pkg::JobChase;
              hold_job_r.phase <= chase_r;
              hold_job_r.color <=
                (mode_step == lsg_pkg::ModeChaseWhite) ? 24'h7F7F7F :
                (mode_step == lsg_pkg::ModeChaseRed)   ? 24'h7F0000 :
                (mode_step == lsg_pkg::ModeChaseGreen) ? 24'h007F00 : 24'h00007F;
              chase_r <= (chase_r == 2'd2) ? 2'd0 : chase_r + 2'd1;
            end
            lsg_pkg::ModeRainbow, lsg_pkg::ModeTvRainbow: begin
              interval_r <= 9'd10;
              hold_r <= 1'b1;
              hold_job_r.kind <= (mode_step == lsg_pkg::ModeRainbow) ?
                                 lsg_pkg::JobRainbow : lsg_pkg::JobTv;
              off_r <= off_r + 8'd1;
            end
            lsg_pkg::ModeRbChase: begin
              interval_r <= 9'd50;
              hold_r <= 1'b1;
              hold_job_r.kind  <= lsg_pkg::JobRbChase;
              hold_job_r.phase <= rbc_r;
              rbc_r <= (rbc_r == 2'd2) ? 2'd0 : rbc_r + 2'd1;
              off_r <= off_r + 8'd1;
            end
            lsg_pkg::ModeRunRed, lsg_pkg::ModeRunGreen, lsg_pkg::ModeRunBlue,
            lsg_pkg::ModePurpleRun: begin
              interval_r <= 9'd50;
              hold_r <= 1'b1;
              hold_job_r.kind <= lsg_pkg::JobRunner;
              hold_job_r.pos  <= run_pos_r;
              hold_job_r.color <=
                (mode_step == lsg_pkg::ModeRunRed)   ? 24'h7F0000 :
                (mode_step == lsg_pkg::ModeRunGreen) ? 24'h007F00 :
                (mode_step == lsg_pkg::ModeRunBlue)  ? 24'h00007F : favorite_color;
              run_pos_r <= (rp_inc >= len_eff) ? 6'd0 : rp_inc[5:0];
            end
            lsg_pkg::ModeRandom: interval_r <= 9'd500;
            lsg_pkg::ModeSetPixel: ;
            default: begin
              if (!drawn_r) begin
                hold_r <= 1'b1;
                hold_job_r.kind  <= lsg_pkg::JobFill;
                hold_job_r.color <= static_color;
                demo_r  <= 1'b0;
                mode_r  <= lsg_pkg::ModeStatic;
                drawn_r <= 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== rtl/core/lsg_back.sv =====
// Back end: pixel store, frame drawing and pixel stream out.
`timescale 1ns / 1ps
module lsg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  lsg_pkg::job_t    job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [5:0]       out_index,
  output logic [23:0]      out_color,
  output logic             out_last
);

  localparam int MAX_PIXELS = lsg_pkg::MaxPixels;
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);

  typedef enum logic [1:0] { StClear, StIdle, StDraw, StEmit } st_t;

  st_t            st_r;
  lsg_pkg::job_t  job_r;
  logic [23:0]    mem [MAX_PIXELS];
  logic [CW-1:0]  cnt_r, len_r;
  logic [1:0]     mod3_r;
  logic [7:0]     wpos_r;
  logic           restore_r;
  logic [23:0]    rd_r;
  logic           rdv_r;       // read data valid for the emit pipeline
  logic [5:0]     rd_idx_r;
  logic           rd_last_r;
  logic           ov_r;
  logic [5:0]     oi_r;
  logic [23:0]    oc_r;
  logic           ol_r;

  // draw value for pixel cnt_r
  logic           we;
  logic [23:0]    wdat;
  logic [8:0]     rb_sum;
  logic [7:0]     wheel_in;
  logic [AW-1:0]  widx;
  logic [CW-1:0]  len_c;

  always_comb begin
    len_c = (job.len > 7'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : CW'(job.len);
    widx = cnt_r[AW-1:0];
    // plain rainbow wraps its wheel position modulo 255
    rb_sum = {1'b0, job_r.offset} + {2'b00, cnt_r};
    wheel_in = (rb_sum >= 9'd255) ? 8'(rb_sum - 9'd255) : rb_sum[7:0];
    we = 1'b0;
    wdat = 24'd0;
    if (st_r == StClear) we = 1'b1;
    else if (st_r == StDraw) begin
      case (job_r.kind)
        lsg_pkg::JobFill: begin we = 1'b1; wdat = job_r.color; end
        lsg_pkg::JobChase: begin
          we = 1'b1; wdat = (mod3_r == job_r.phase && cnt_r < len_r) ? job_r.color : 24'd0;
        end
        lsg_pkg::JobRunner: begin
          we = 1'b1;
          wdat = (cnt_r == CW'(job_r.pos) && cnt_r < len_r) ? job_r.color : 24'd0;
        end
        lsg_pkg::JobRainbow: begin
          we = cnt_r < len_r; wdat = lsg_pkg::wheel(wheel_in);
        end
        lsg_pkg::JobTv: begin
          we = cnt_r < len_r;
          wdat = ({1'b0, cnt_r} < {1'b0, job_r.tv_first}) ? 24'd0 : lsg_pkg::wheel(wpos_r);
        end
        lsg_pkg::JobRbChase: begin
          // phase hit: i = base + phase, wheel uses base
          we = cnt_r < len_r && mod3_r == job_r.phase;
          wdat = restore_r ? 24'd0 : lsg_pkg::wheel(wpos_r - 8'(job_r.phase));
        end
        default: ;
      endcase
    end
  end

  assign job_ready = (st_r == StIdle);
  logic emit_go;
  assign emit_go = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (we) mem[widx] <= wdat;
    if (st_r == StEmit && (!rdv_r || emit_go)) rd_r <= mem[widx];
    if (job_valid && job_ready && job.kind == lsg_pkg::JobPut &&
        {1'b0, job.pos} < {1'b0, len_c}) mem[job.pos[AW-1:0]] <= job.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StClear; cnt_r <= '0; rdv_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (rdv_r && emit_go) begin
        ov_r <= 1'b1; oc_r <= rd_r; oi_r <= rd_idx_r; ol_r <= rd_last_r; rdv_r <= 1'b0;
      end
      case (st_r)
        StClear: begin
          if (cnt_r == CW'(MAX_PIXELS - 1)) begin st_r <= StIdle; cnt_r <= '0; end
          else cnt_r <= cnt_r + CW'(1);
        end
        StIdle: if (job_valid) begin
          job_r <= job; len_r <= len_c; cnt_r <= '0; mod3_r <= '0;
          wpos_r <= job.offset; restore_r <= 1'b0;
          if (job.kind == lsg_pkg::JobPut) st_r <= (len_c == '0) ? StIdle : StEmit;
          else st_r <= StDraw;
        end
        StDraw: begin
          mod3_r <= (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
          wpos_r <= wpos_r + 8'd1;
          if ((job_r.kind == lsg_pkg::JobFill || job_r.kind == lsg_pkg::JobChase ||
               job_r.kind == lsg_pkg::JobRunner) ? (cnt_r == CW'(MAX_PIXELS - 1))
                                                 : (cnt_r + CW'(1) >= len_r)) begin
            cnt_r <= '0;
            st_r <= restore_r ? StIdle : ((len_r == '0) ? StIdle : StEmit);
          end else cnt_r <= cnt_r + CW'(1);
        end
        StEmit: begin
          // one read per cycle when the out stage can take it
          if (!rdv_r || emit_go) begin
            rdv_r <= 1'b1;
            rd_idx_r <= 6'(cnt_r);
            rd_last_r <= (cnt_r + CW'(1) == len_r);
            if (cnt_r + CW'(1) == len_r) begin
              cnt_r <= '0; mod3_r <= '0; wpos_r <= job_r.offset;
              if (job_r.kind == lsg_pkg::JobRbChase) begin
                restore_r <= 1'b1; st_r <= StDraw;
              end else st_r <= StIdle;
            end else cnt_r <= cnt_r + CW'(1);
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_index = oi_r;
  assign out_color = oc_r;
  assign out_last  = ol_r;

endmodule

// ===== rtl/core/led_strip_effect_generator_core.sv =====
// Top level of the LED strip effect generator: APB registers, front and back ends.
`timescale 1ns / 1ps
// Each tick transfer advances the frame and demo timers; when the frame
// interval runs out the front end issues at most one frame job into a one-entry
// buffer and the back end draws it into the 24-bit pixel store and streams
// the pixels out, the last one marked with tlast. A frame takes a draw pass
// (whole store for static, chase and runner, strip_length pixels for the
// rainbows, none for a wipe) and then strip_length pixels at one per cycle
// while the receiver is ready, plus a second draw pass that blanks the lit
// pixels for the rainbow chase; the tick channel stalls only while a job
// waits in the buffer. After reset the store is swept to black before the
// first frame is drawn.
// tdata out: pixel_index[5:0], red[13:6], green[21:14], blue[29:22].
module led_strip_effect_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ms_elapsed[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_index, red, green, blue
  output logic        out_tlast,  // frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [4:0]  mode_sel_r;
  logic [23:0] static_r, fav_r;
  logic [6:0]  len_r, tv_r;
  logic [15:0] ivl_r;
  logic        demo;
  logic        wr;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ridx = cfg_paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_sel_r <= '0; static_r <= '0; fav_r <= 24'h8900B7;
      len_r <= 7'd60; tv_r <= '0; ivl_r <= 16'd5000;
    end else if (wr) begin
      case (ridx)
        lsg_pkg::RegModeSelect:  mode_sel_r <= cfg_pwdata[4:0];
        lsg_pkg::RegStaticColor: static_r   <= cfg_pwdata[23:0];
        lsg_pkg::RegFavColor:    fav_r      <= cfg_pwdata[23:0];
        lsg_pkg::RegStripLength: len_r      <= cfg_pwdata[6:0];
        lsg_pkg::RegTvFirst:     tv_r       <= cfg_pwdata[6:0];
        lsg_pkg::RegPatternIvl:  ivl_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      lsg_pkg::RegModeSelect:  cfg_prdata = {27'd0, mode_sel_r};
      lsg_pkg::RegDemoEnable:  cfg_prdata = {31'd0, demo};
      lsg_pkg::RegStaticColor: cfg_prdata = {8'd0, static_r};
      lsg_pkg::RegFavColor:    cfg_prdata = {8'd0, fav_r};
      lsg_pkg::RegStripLength: cfg_prdata = {25'd0, len_r};
      lsg_pkg::RegTvFirst:     cfg_prdata = {25'd0, tv_r};
      lsg_pkg::RegPatternIvl:  cfg_prdata = {16'd0, ivl_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  logic          job_valid, job_ready;
  lsg_pkg::job_t job;
  logic [5:0]    o_idx;
  logic [23:0]   o_col;

  lsg_front u_front (
    .clk, .rst_n,
    .tick_valid(in_tvalid), .tick_ready(in_tready), .ms_elapsed(in_tdata[3:0]),
    .wr_mode(wr && ridx == lsg_pkg::RegModeSelect), .wr_mode_val(cfg_pwdata[4:0]),
    .wr_static(wr && ridx == lsg_pkg::RegStaticColor),
    .wr_demo(wr && ridx == lsg_pkg::RegDemoEnable), .demo_val(cfg_pwdata[0]),
    .static_color(static_r), .favorite_color(fav_r), .strip_len(len_r),
    .tv_first_pixel(tv_r), .pattern_interval(ivl_r), .demo_enable(demo),
    .job_valid, .job_ready, .job
  );

  lsg_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_index(o_idx), .out_color(o_col), .out_last(out_tlast)
  );

  assign out_tdata = {2'b0, o_col[7:0], o_col[15:8], o_col[23:16], o_idx};

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel changed");

  // ticks are refused only while a frame job waits
  a_tick_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> job_valid)
    else $error("tick stalled without pending job");

endmodule

// ===== tb/sv/led_strip_effect_generator_core_tb.sv =====
// Testbench for the LED strip effect generator: tick stimulus, APB setup, pixel scoreboard.
`timescale 1ns / 1ps
module led_strip_effect_generator_core_tb;

  typedef struct {
    logic [5:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  // Scoreboard: mirrors the generator state and queues the pixels each tick should emit
  class strip_scoreboard;
    logic [4:0]  mode_sel;
    logic        demo_on;
    logic [23:0] static_rgb, fav_rgb;
    logic [6:0]  strip_len, tv_first;
    logic [15:0] pattern_ms;
    logic [23:0] store[64];
    int          frame_timer, demo_timer, frame_ivl;
    logic [4:0]  cur_mode;
    int          wipe_pos, runner_pos, chase_ph, rb_chase_ph, rb_off;
    bit          wipe_blank, static_done;
    pixel_t      pending[$];
    int          mismatches;

    function void reset_state();
      mode_sel = lsg_pkg::ModeStatic; demo_on = 0; static_rgb = 0; fav_rgb = 24'h8900B7;
      strip_len = 60; tv_first = 0; pattern_ms = 5000;
      foreach (store[i]) store[i] = 0;
      frame_timer = 0; demo_timer = 0; frame_ivl = 50; cur_mode = lsg_pkg::ModeStatic;
      wipe_pos = 0; runner_pos = 0; chase_ph = 0; rb_chase_ph = 0; rb_off = 0;
      wipe_blank = 0; static_done = 0;
      pending.delete(); mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        lsg_pkg::RegModeSelect: begin
          mode_sel = v[4:0]; cur_mode = v[4:0]; static_done = 0;
        end
        lsg_pkg::RegDemoEnable:  demo_on = v[0];
        lsg_pkg::RegStaticColor: begin
          static_rgb = v[23:0]; static_done = 0;
        end
        lsg_pkg::RegFavColor:    fav_rgb = v[23:0];
        lsg_pkg::RegStripLength: strip_len = v[6:0];
        lsg_pkg::RegTvFirst:     tv_first = v[6:0];
        lsg_pkg::RegPatternIvl:  pattern_ms = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [23:0] color_wheel(int pos);
      int p;
      p = 255 - (pos & 255);
      if (p < 85) return {8'(255 - p * 3), 8'd0, 8'(p * 3)};
      if (p < 170) begin
        p -= 85;
        return {8'd0, 8'(p * 3), 8'(255 - p * 3)};
      end
      p -= 170;
      return {8'(p * 3), 8'(255 - p * 3), 8'd0};
    endfunction

    function void put(int idx, logic [23:0] c, int len);
      if (idx < len && idx < 64) store[idx] = c;
    endfunction

    function void queue_frame(int len);
      pixel_t px;
      for (int i = 0; i < len; i++) begin
        px.index = i[5:0];
        {px.red, px.green, px.blue} = store[i];
        px.frame_end = (i + 1 == len);
        pending.push_back(px);
      end
    endfunction

    function void clear_store();
      foreach (store[i]) store[i] = 0;
    endfunction

    function void wipe(logic [23:0] c, int len);
      frame_ivl = 50;
      put(wipe_pos, wipe_blank ? 24'd0 : c, len);
      wipe_pos++;
      if (wipe_pos >= len) begin
        wipe_pos = 0; wipe_blank = !wipe_blank;
      end
    endfunction

    function void chase(logic [23:0] c, int len);
      frame_ivl = 50;
      clear_store();
      for (int i = chase_ph; i < len; i += 3) put(i, c, len);
      chase_ph = (chase_ph + 1) % 3;
    endfunction

    function void runner(logic [23:0] c, int len);
      frame_ivl = 50;
      clear_store();
      put(runner_pos, c, len);
      runner_pos++;
      if (runner_pos >= len) runner_pos = 0;
    endfunction

    // one accepted tick transfer
    function void note_tick(logic [3:0] ms);
      int len;
      len = (strip_len > 64) ? 64 : strip_len;
      frame_timer = (frame_timer + ms > 65535) ? 65535 : frame_timer + ms;
      demo_timer = (demo_timer + ms > 65535) ? 65535 : demo_timer + ms;
      if (demo_on && demo_timer >= pattern_ms) begin
        demo_timer = 0;
        cur_mode = cur_mode + 5'd1;
        if (cur_mode > lsg_pkg::ModeDemoLast || cur_mode == lsg_pkg::ModeStatic)
          cur_mode = lsg_pkg::ModeWipeRed;
      end
      if (frame_timer < frame_ivl) return;
      frame_timer = 0;
      case (cur_mode)
        lsg_pkg::ModeWipeRed:    wipe(24'hFF0000, len);
        lsg_pkg::ModeWipeGreen:  wipe(24'h00FF00, len);
        lsg_pkg::ModeWipeBlue:   wipe(24'h0000FF, len);
        lsg_pkg::ModePurpleWipe: wipe(fav_rgb, len);
        lsg_pkg::ModeChaseWhite: chase(24'h7F7F7F, len);
        lsg_pkg::ModeChaseRed:   chase(24'h7F0000, len);
        lsg_pkg::ModeChaseGreen: chase(24'h007F00, len);
        lsg_pkg::ModeChaseBlue:  chase(24'h00007F, len);
        lsg_pkg::ModeRainbow: begin
          frame_ivl = 10;
          for (int i = 0; i < len; i++) put(i, color_wheel((i + rb_off) % 255), len);
          rb_off = (rb_off + 1) & 255;
        end
        lsg_pkg::ModeTvRainbow: begin
          frame_ivl = 10;
          for (int i = 0; i < len; i++)
            put(i, (i < tv_first) ? 24'd0 : color_wheel((i + rb_off) & 255), len);
          rb_off = (rb_off + 1) & 255;
        end
        lsg_pkg::ModeRbChase: begin
          // lit pixels go back to black once the frame is out
          frame_ivl = 50;
          for (int i = 0; i < len; i += 3)
            put(i + rb_chase_ph, color_wheel((i + rb_off) & 255), len);
          queue_frame(len);
          for (int i = 0; i < len; i += 3) put(i + rb_chase_ph, 24'd0, len);
          rb_chase_ph = (rb_chase_ph + 1) % 3;
          rb_off = (rb_off + 1) & 255;
          return;
        end
        lsg_pkg::ModeRunRed:    runner(24'h7F0000, len);
        lsg_pkg::ModeRunGreen:  runner(24'h007F00, len);
        lsg_pkg::ModeRunBlue:   runner(24'h00007F, len);
        lsg_pkg::ModePurpleRun: runner(fav_rgb, len);
        lsg_pkg::ModeRandom: begin
          frame_ivl = 500;
          return;
        end
        lsg_pkg::ModeSetPixel: return;
        default: begin
          // static and unknown numbers: one fill, then back to static, demo off
          if (static_done) return;
          foreach (store[i]) store[i] = static_rgb;
          demo_on = 0; cur_mode = lsg_pkg::ModeStatic; static_done = 1;
        end
      endcase
      queue_frame(len);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected pixel %0d", got.index);
        return;
      end
      want = pending.pop_front();
      if (got.index !== want.index || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel exp idx %0d rgb %h%h%h last %b, got idx %0d rgb %h%h%h last %b",
                   want.index, want.red, want.green, want.blue, want.frame_end,
                   got.index, got.red, got.green, got.blue, got.frame_end);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  strip_scoreboard sb;
  bit calm;          // no idling on either side
  int hold_off;      // receiver stall cycles still to run

  led_strip_effect_generator_core u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random backpressure plus a long forced stall
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  // pixel transfer monitor
  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.index = out_tdata[5:0];
      got.red = out_tdata[13:6];
      got.green = out_tdata[21:14];
      got.blue = out_tdata[29:22];
      got.frame_end = out_tlast;
      sb.check_pixel(got);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_tick(logic [3:0] ms);
    if (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'($urandom), ms};   // upper bits are padding, toggled on purpose
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(ms);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic setup(logic [4:0] mode, logic demo, logic [23:0] st, logic [23:0] fav,
                       logic [6:0] len, logic [6:0] tv, logic [15:0] ivl);
    write_reg(lsg_pkg::RegStripLength, len);
    write_reg(lsg_pkg::RegTvFirst, tv);
    write_reg(lsg_pkg::RegPatternIvl, ivl);
    write_reg(lsg_pkg::RegFavColor, fav);
    write_reg(lsg_pkg::RegStaticColor, st);
    write_reg(lsg_pkg::RegDemoEnable, demo);
    write_reg(lsg_pkg::RegModeSelect, mode);
  endtask

  initial begin
    logic [4:0]  mode;
    logic [6:0]  len;
    logic [15:0] ivl;
    sb = new();
    sb.reset_state();
    rst_n = 0; calm = 0; hold_off = 0;
    in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, tick extremes, static once, unknown mode, short TV rainbow and rainbow chase
    send_tick(4'd0);
    repeat (4) send_tick(4'd15);
    drain();
    setup(5'd31, 1, 24'hFFFFFF, 24'h000000, 7'd64, 7'd64, 16'd65535);
    repeat (4) send_tick(4'd15);
    drain();
    setup(lsg_pkg::ModeTvRainbow, 0, 24'h000000, 24'hFFFFFF, 7'd1, 7'd0, 16'd1);
    repeat (3) send_tick(4'd15);
    drain();
    setup(lsg_pkg::ModeRbChase, 0, 24'hA5A5A5, 24'h5A5A5A, 7'd2, 7'd5, 16'd1);
    repeat (8) send_tick(4'd15);
    drain();

    // long receiver stall while rainbow frames keep coming
    setup(lsg_pkg::ModeRainbow, 0, 24'h123456, 24'h654321, 7'd64, 7'd10, 16'd5000);
    hold_off = 600;
    repeat (12) send_tick(4'd15);
    drain();

    // random phases
    for (int ph = 0; ph < 23; ph++) begin
      calm = (ph == 6);
      mode = ($urandom_range(7) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
      case ($urandom_range(3))
        0: len = 7'd1;
        1: len = 7'd64;
        default: len = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(3))
        0: ivl = 16'd1;
        1: ivl = 16'd65535;
        default: ivl = 16'($urandom_range(20, 300));
      endcase
      setup(mode, $urandom_range(1), 24'($urandom), 24'($urandom), len,
            7'($urandom_range(0, 64)), ivl);
      for (int k = 0; k < 18; k++) begin
        send_tick(4'($urandom_range(0, 15)));
        if (ph == 3 && k == 9) drain();
      end
      drain();
    end
    calm = 0;

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
